[hdl/cbt_pkg.sv]
// ----------------------------------------------------------------------------
// cbt_pkg
// Shared types and constants of the clipped colour-key block transfer.
// ----------------------------------------------------------------------------
package cbt_pkg;

	localparam int unsigned CfgIdxW  = 3;
	localparam int unsigned CfgDataW = 11;
	localparam int unsigned PixelW   = 16;
	localparam int unsigned AddrW    = 16;
	localparam int unsigned CountW   = 10;
	localparam int unsigned ClipW    = 14;
	localparam int unsigned OpaqueBit = 15;

	typedef enum logic [CfgIdxW-1:0] {
		REG_DEST_X        = 3'd0,
		REG_DEST_Y        = 3'd1,
		REG_WINDOW_WIDTH  = 3'd2,
		REG_WINDOW_HEIGHT = 3'd3,
		REG_WINDOW_COL_OFF = 3'd4,
		REG_WINDOW_ROW_OFF = 3'd5,
		REG_SOURCE_WIDTH  = 3'd6,
		REG_SOURCE_HEIGHT = 3'd7
	} cfg_reg_t;

	localparam logic [10:0] SourceWidthReset  = 11'd256;
	localparam logic [10:0] SourceHeightReset = 11'd192;

	// clipped window of one axis: first source index, one past the last,
	// and the framebuffer position of the first index
	typedef struct packed {
		logic signed [ClipW-1:0] first;
		logic signed [ClipW-1:0] last;
		logic [CountW-1:0]       start;
	} axis_clip_t;

endpackage

[hdl/cbt_if.sv]
// ----------------------------------------------------------------------------
// cbt_if
// Valid/ready channels of the block transfer: source pixels and writes.
// ----------------------------------------------------------------------------
interface cbt_pixel_if;
	logic        valid;
	logic        ready;
	logic [15:0] pixel_color;

	modport source (output valid, output pixel_color, input ready);
	modport sink (input valid, input pixel_color, output ready);
endinterface

interface cbt_write_if;
	logic        valid;
	logic        ready;
	logic [15:0] dest_address;
	logic [15:0] dest_color;

	modport source (output valid, output dest_address, output dest_color, input ready);
	modport sink (input valid, input dest_address, input dest_color, output ready);
endinterface

[hdl/clipped_transparent_blit_top.sv]
// A result passes the input stage and the result register before it is offered.
// Throughput: one pixel per cycle; the clipped window is recomputed every
// cycle from the configuration registers and held in a register.
// Stalls only when the result register is full and not taken.
// Reset clears the counters and pipeline valids and loads the register defaults.
// ----------------------------------------------------------------------------
// clipped_transparent_blit_top
// Colour-key block transfer with window clipping: opaque source pixels inside
// the clipped window become framebuffer writes.
// ----------------------------------------------------------------------------
module clipped_transparent_blit_top
	import cbt_pkg::*;
#(
	parameter int DEST_WIDTH  = 256,
	parameter int DEST_HEIGHT = 192
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	cbt_pixel_if.sink           pixels,
	cbt_write_if.source         writes
);

	localparam logic [10:0] DestW = 11'(DEST_WIDTH);

	logic signed [10:0] dest_x_q;
	logic signed [10:0] dest_y_q;
	logic [10:0]        win_w_q;
	logic [10:0]        win_h_q;
	logic [9:0]         win_col_q;
	logic [9:0]         win_row_q;
	logic [10:0]        src_w_q;
	logic [10:0]        src_h_q;

	logic [CountW-1:0]  col_q;
	logic [CountW-1:0]  row_q;
	logic [CountW:0]    col_inc;
	logic [CountW:0]    row_inc;
	logic               col_wrap;

	logic               v_s1;
	logic [PixelW-1:0]  pix_s1;
	logic [CountW-1:0]  col_s1;
	logic [CountW-1:0]  row_s1;

	logic               out_v_q;
	logic [AddrW-1:0]   addr_q;
	logic [PixelW-1:0]  color_q;

	axis_clip_t         clip_x;
	axis_clip_t         clip_y;

	logic               out_free;
	logic               in_acc;
	logic               hit;
	logic signed [ClipW-1:0] dc;
	logic signed [ClipW-1:0] dr;
	logic [21:0]        addr_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dest_x_q  <= '0;
			dest_y_q  <= '0;
			win_w_q   <= '0;
			win_h_q   <= '0;
			win_col_q <= '0;
			win_row_q <= '0;
			src_w_q   <= SourceWidthReset;
			src_h_q   <= SourceHeightReset;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_DEST_X:         dest_x_q  <= $signed(cfg_data);
				REG_DEST_Y:         dest_y_q  <= $signed(cfg_data);
				REG_WINDOW_WIDTH:   win_w_q   <= cfg_data;
				REG_WINDOW_HEIGHT:  win_h_q   <= cfg_data;
				REG_WINDOW_COL_OFF: win_col_q <= cfg_data[9:0];
				REG_WINDOW_ROW_OFF: win_row_q <= cfg_data[9:0];
				REG_SOURCE_WIDTH:   src_w_q   <= cfg_data;
				REG_SOURCE_HEIGHT:  src_h_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	cbt_clip_axis #(.DST_SIZE(DEST_WIDTH)) u_clip_x (
		.clk      (clk),
		.pos      (dest_x_q),
		.size     (win_w_q),
		.offset   (win_col_q),
		.src_size (src_w_q),
		.clip     (clip_x)
	);

	cbt_clip_axis #(.DST_SIZE(DEST_HEIGHT)) u_clip_y (
		.clk      (clk),
		.pos      (dest_y_q),
		.size     (win_h_q),
		.offset   (win_row_q),
		.src_size (src_h_q),
		.clip     (clip_y)
	);

	assign out_free      = !out_v_q || writes.ready;
	assign pixels.ready  = !v_s1 || out_free;
	assign in_acc        = pixels.valid && pixels.ready;

	// raster position counters
	assign col_inc  = {1'b0, col_q} + 1'b1;
	assign row_inc  = {1'b0, row_q} + 1'b1;
	assign col_wrap = (col_inc >= src_w_q) || col_inc[CountW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_acc) begin
			if (col_wrap) begin
				col_q <= '0;
				if ((row_inc >= src_h_q) || row_inc[CountW]) begin
					row_q <= '0;
				end else begin
					row_q <= row_inc[CountW-1:0];
				end
			end else begin
				col_q <= col_inc[CountW-1:0];
			end
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (pixels.ready) begin
			v_s1 <= pixels.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			pix_s1 <= pixels.pixel_color;
			col_s1 <= col_q;
			row_s1 <= row_q;
		end
	end

	// window test and framebuffer address
	assign dc = $signed({4'b0000, col_s1}) - clip_x.first + $signed({4'b0000, clip_x.start});
	assign dr = $signed({4'b0000, row_s1}) - clip_y.first + $signed({4'b0000, clip_y.start});

	assign hit = pix_s1[OpaqueBit]
		&& ($signed({4'b0000, col_s1}) >= clip_x.first)
		&& ($signed({4'b0000, col_s1}) < clip_x.last)
		&& ($signed({4'b0000, row_s1}) >= clip_y.first)
		&& ($signed({4'b0000, row_s1}) < clip_y.last)
		&& (dc < ClipW'(DEST_WIDTH))
		&& (dr < ClipW'(DEST_HEIGHT));

	assign addr_full = 22'(dr[10:0]) * 22'(DestW) + 22'(dc[10:0]);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_free) begin
			out_v_q <= v_s1 && hit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && v_s1 && hit) begin
			addr_q  <= addr_full[AddrW-1:0];
			color_q <= pix_s1;
		end
	end

	assign writes.valid        = out_v_q;
	assign writes.dest_address = addr_q;
	assign writes.dest_color   = color_q;

endmodule

[hdl/cbt_clip_axis.sv]
// ----------------------------------------------------------------------------
// cbt_clip_axis
// Clips the window of one axis against source and framebuffer; registered.
// ----------------------------------------------------------------------------
module cbt_clip_axis
	import cbt_pkg::*;
#(
	parameter int DST_SIZE = 256
) (
	input  logic              clk,
	input  logic signed [10:0] pos,
	input  logic [10:0]       size,
	input  logic [9:0]        offset,
	input  logic [10:0]       src_size,
	output axis_clip_t        clip
);

	localparam logic signed [ClipW-1:0] DstSize = ClipW'(DST_SIZE);

	logic signed [ClipW-1:0] pos_w;
	logic signed [ClipW-1:0] size_w;
	logic signed [ClipW-1:0] off_w;
	logic signed [ClipW-1:0] src_w;
	logic signed [ClipW-1:0] first_d;
	logic signed [ClipW-1:0] last_d;
	logic [CountW-1:0]       start_d;
	axis_clip_t              clip_q;

	assign pos_w  = ClipW'(pos);
	assign size_w = $signed({3'b000, size});
	assign off_w  = $signed({4'b0000, offset});
	assign src_w  = $signed({3'b000, src_size});

	always_comb begin
		if (pos_w < 0) begin
			first_d = off_w - pos_w;
			last_d  = off_w + size_w;
			if (last_d > src_w) begin
				last_d = src_w;
			end
			start_d = '0;
		end else begin
			first_d = off_w;
			if (pos_w + size_w > DstSize) begin
				last_d = off_w + DstSize - pos_w;
			end else begin
				last_d = off_w + size_w;
			end
			start_d = pos[CountW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		clip_q.first <= first_d;
		clip_q.last  <= last_d;
		clip_q.start <= start_d;
	end

	assign clip = clip_q;

endmodule

[hdl/cbt_checker.sv]
// ----------------------------------------------------------------------------
// cbt_checker
// Port-level checks of the block transfer, bound to the top level.
// ----------------------------------------------------------------------------
module cbt_checker #(
	parameter int DEST_WIDTH  = 256,
	parameter int DEST_HEIGHT = 192
) (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] out_address,
	input logic [15:0] out_color
);

	localparam longint unsigned Area = longint'(DEST_WIDTH) * longint'(DEST_HEIGHT);

	// hold a stalled transaction
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_address) && $stable(out_color))
		else $error("stalled write transaction changed");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_color[15] && (Area > 64'd65536 || 64'(out_address) < Area))
		else $error("write of transparent pixel or outside framebuffer");

	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("pixel input stalled without output back-pressure");

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("write transaction without a pixel two cycles earlier");

endmodule

bind clipped_transparent_blit_top cbt_checker #(
	.DEST_WIDTH  (DEST_WIDTH),
	.DEST_HEIGHT (DEST_HEIGHT)
) u_cbt_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (pixels.valid),
	.in_ready    (pixels.ready),
	.out_valid   (writes.valid),
	.out_ready   (writes.ready),
	.out_address (writes.dest_address),
	.out_color   (writes.dest_color)
);

[sim/clipped_transparent_blit_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clipped_transparent_blit_top_tb
// Streams source pixels into the block transfer under a series of window,
// placement and source-size settings, predicts every framebuffer write from a
// clipping model of its own and checks each write transaction in order.
// Both channels idle at random; the write side holds off once for a long
// stretch so that the pixel side backs up.
// ----------------------------------------------------------------------------
module clipped_transparent_blit_top_tb;
	import cbt_pkg::*;

	localparam int DEST_W = 256;
	localparam int DEST_H = 192;
	localparam int COUNT_LIMIT = 1023;

	typedef struct packed {
		logic [AddrW-1:0]  addr;
		logic [PixelW-1:0] color;
	} fb_write_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CfgDataW-1:0] cfg_data;

	cbt_pixel_if pix_ch();
	cbt_write_if wr_ch();

	clipped_transparent_blit_top #(
		.DEST_WIDTH  (DEST_W),
		.DEST_HEIGHT (DEST_H)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pixels    (pix_ch),
		.writes    (wr_ch)
	);

	logic [CfgDataW-1:0] blit_cfg [8];
	int                  src_col;
	int                  src_row;
	logic [PixelW-1:0]   pixel_backlog [$];
	fb_write_t           pending_writes [$];
	int                  pixels_taken;
	int                  writes_seen;
	int                  fault_count;
	int                  source_gap;
	bit                  source_calm;
	int                  sink_hold;
	bit                  sink_calm;
	bit                  long_hold_done;

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic int idle_len(input bit calm);
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic void clip_axis(input int pos, input int span_in, input int off_in,
			input int src_len, input int dst_len, output int first, output int span,
			output int start);
		span  = span_in;
		first = off_in;
		if (pos < 0) begin
			span  = span + pos;
			first = first - pos;
			if (first + span > src_len)
				span = src_len - first;
			start = 0;
		end else begin
			if (pos + span > dst_len)
				span = dst_len - pos;
			start = pos;
		end
	endfunction

	function automatic int next_count(input int n, input logic [CfgDataW-1:0] lim);
		int nxt;
		nxt = n + 1;
		if (nxt >= int'(lim) || nxt > COUNT_LIMIT)
			return 0;
		return nxt;
	endfunction

	function automatic void blit_pixel(input logic [PixelW-1:0] px);
		int xo, xw, xs, yo, yh, ys, dc, dr;
		fb_write_t w;
		clip_axis(int'($signed(blit_cfg[REG_DEST_X])), int'(blit_cfg[REG_WINDOW_WIDTH]),
			int'(blit_cfg[REG_WINDOW_COL_OFF]), int'(blit_cfg[REG_SOURCE_WIDTH]), DEST_W,
			xo, xw, xs);
		clip_axis(int'($signed(blit_cfg[REG_DEST_Y])), int'(blit_cfg[REG_WINDOW_HEIGHT]),
			int'(blit_cfg[REG_WINDOW_ROW_OFF]), int'(blit_cfg[REG_SOURCE_HEIGHT]), DEST_H,
			yo, yh, ys);
		if (src_col >= xo && src_col < xo + xw && src_row >= yo && src_row < yo + yh &&
				px[OpaqueBit]) begin
			dc = src_col - xo + xs;
			dr = src_row - yo + ys;
			if (dc >= 0 && dc < DEST_W && dr >= 0 && dr < DEST_H) begin
				w.addr  = AddrW'(dr * DEST_W + dc);
				w.color = px;
				pending_writes.push_back(w);
			end
		end
		src_col = next_count(src_col, blit_cfg[REG_SOURCE_WIDTH]);
		if (src_col == 0)
			src_row = next_count(src_row, blit_cfg[REG_SOURCE_HEIGHT]);
	endfunction

	// pixel side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_ch.valid       <= 1'b0;
			pix_ch.pixel_color <= '0;
			source_gap         <= 0;
		end else begin
			if (pix_ch.valid && pix_ch.ready) begin
				blit_pixel(pix_ch.pixel_color);
				pixels_taken <= pixels_taken + 1;
			end
			if (!pix_ch.valid || pix_ch.ready) begin
				if (source_gap != 0) begin
					pix_ch.valid <= 1'b0;
					source_gap   <= source_gap - 1;
				end else if (pixel_backlog.size() != 0) begin
					pix_ch.valid       <= 1'b1;
					pix_ch.pixel_color <= pixel_backlog.pop_front();
					source_gap         <= idle_len(source_calm);
					if ($urandom_range(0, 149) == 0)
						source_calm <= !source_calm;
				end else begin
					pix_ch.valid <= 1'b0;
				end
			end
		end
	end

	// write side
	always @(posedge clk or negedge arst_n) begin
		fb_write_t want;
		if (!arst_n) begin
			wr_ch.ready <= 1'b0;
			sink_hold   <= 0;
		end else begin
			if (wr_ch.valid && wr_ch.ready) begin
				writes_seen <= writes_seen + 1;
				if (pending_writes.size() == 0) begin
					if (fault_count < 10)
						$display("%0t: unexpected write addr=%h color=%h", $realtime,
							wr_ch.dest_address, wr_ch.dest_color);
					fault_count <= fault_count + 1;
				end else begin
					want = pending_writes.pop_front();
					if (want.addr !== wr_ch.dest_address || want.color !== wr_ch.dest_color) begin
						if (fault_count < 10)
							$display("%0t: write mismatch: expected addr=%h color=%h, got addr=%h color=%h",
								$realtime, want.addr, want.color, wr_ch.dest_address,
								wr_ch.dest_color);
						fault_count <= fault_count + 1;
					end
				end
			end
			if (sink_hold != 0) begin
				wr_ch.ready <= 1'b0;
				sink_hold   <= sink_hold - 1;
			end else if (!long_hold_done && writes_seen >= 10 && pixel_backlog.size() >= 64) begin
				wr_ch.ready    <= 1'b0;
				sink_hold      <= 400;
				long_hold_done <= 1'b1;
			end else begin
				wr_ch.ready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					sink_hold <= idle_len(sink_calm);
				if ($urandom_range(0, 199) == 0)
					sink_calm <= !sink_calm;
			end
		end
	end

	task automatic wait_idle();
		while (pixel_backlog.size() != 0 || pix_ch.valid || pending_writes.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input int value);
		logic [CfgDataW-1:0] v;
		v = CfgDataW'(value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		if (idx == REG_WINDOW_COL_OFF || idx == REG_WINDOW_ROW_OFF)
			v[CfgDataW-1] = 1'b0;
		blit_cfg[idx] = v;
	endtask

	// drain, let the pipeline settle, then load a whole setting
	task automatic reconfigure(input int setting [8]);
		wait_idle();
		repeat (4) @(posedge clk);
		for (int i = 0; i < 8; i++)
			write_reg(cfg_reg_t'(i), setting[i]);
		@(posedge clk);
		cfg_we <= 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic int pick_size(input int typical);
		case ($urandom_range(0, 9))
			0: return $urandom_range(0, 2047);
			1: return ($urandom_range(0, 1) != 0) ? 1 : 1024;
			2: return 0;
			default: return $urandom_range(1, typical);
		endcase
	endfunction

	function automatic int pick_pos(input int dst_len);
		case ($urandom_range(0, 9))
			0: return -1024;
			1: return 1023;
			2: return int'($urandom_range(0, 2047)) - 1024;
			default: return int'($urandom_range(0, dst_len + 24)) - 16;
		endcase
	endfunction

	function automatic int pick_span(input int typical);
		case ($urandom_range(0, 9))
			0: return 1024;
			1: return $urandom_range(0, 2047);
			2: return 0;
			default: return $urandom_range(1, typical + 4);
		endcase
	endfunction

	function automatic int pick_offset(input int typical);
		case ($urandom_range(0, 9))
			0: return 1023;
			1: return $urandom_range(0, 2047);
			default: return $urandom_range(0, typical);
		endcase
	endfunction

	task automatic random_setting(output int s [8]);
		int sw, sh;
		sw = $urandom_range(1, 24);
		sh = $urandom_range(1, 16);
		s[REG_SOURCE_WIDTH]   = ($urandom_range(0, 3) == 0) ? pick_size(24) : sw;
		s[REG_SOURCE_HEIGHT]  = ($urandom_range(0, 3) == 0) ? pick_size(16) : sh;
		s[REG_DEST_X]         = pick_pos(DEST_W);
		s[REG_DEST_Y]         = pick_pos(DEST_H);
		s[REG_WINDOW_WIDTH]   = pick_span(sw);
		s[REG_WINDOW_HEIGHT]  = pick_span(sh);
		s[REG_WINDOW_COL_OFF] = pick_offset(sw - 1);
		s[REG_WINDOW_ROW_OFF] = pick_offset(sh - 1);
	endtask

	initial begin
		logic [PixelW-1:0] px;
		int setting [8];
		int n_pixels;
		clk            = 1'b1;
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		pix_ch.valid   = 1'b0;
		pix_ch.pixel_color = '0;
		wr_ch.ready    = 1'b0;
		src_col        = 0;
		src_row        = 0;
		pixels_taken   = 0;
		writes_seen    = 0;
		fault_count    = 0;
		source_gap     = 0;
		source_calm    = 1'b0;
		sink_hold      = 0;
		sink_calm      = 1'b0;
		long_hold_done = 1'b0;
		foreach (blit_cfg[i])
			blit_cfg[i] = '0;
		blit_cfg[REG_SOURCE_WIDTH]  = SourceWidthReset;
		blit_cfg[REG_SOURCE_HEIGHT] = SourceHeightReset;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// full window over a 4x3 source, extreme colours first
		setting = '{0, 0, 4, 3, 0, 0, 4, 3};
		reconfigure(setting);
		pixel_backlog.push_back(16'hFFFF);
		pixel_backlog.push_back(16'h8000);
		pixel_backlog.push_back(16'h7FFF);
		pixel_backlog.push_back(16'h0000);
		repeat (8)
			pixel_backlog.push_back(16'($urandom_range(0, 65535)) | 16'h8000);

		// negative placement on both axes, window cut at the source edge
		setting = '{-2, -1, 5, 3, 1, 0, 4, 3};
		reconfigure(setting);
		repeat (8)
			pixel_backlog.push_back(16'($urandom_range(0, 65535)) | 16'h8000);

		// zero source width, window cut at right and bottom framebuffer edges
		setting = '{250, 190, 10, 5, 0, 0, 0, 3};
		reconfigure(setting);
		repeat (4)
			pixel_backlog.push_back(16'($urandom_range(0, 65535)) | 16'h8000);

		// long rows that run past the framebuffer
		setting = '{-2, 0, 400, 4, 0, 0, 300, 4};
		reconfigure(setting);
		repeat (320)
			pixel_backlog.push_back(16'($urandom_range(0, 65535)) | 16'h8000);

		// extremes: empty windows after clipping, out-of-range source sizes
		setting = '{-1024, 1023, 1024, 1024, 1023, 1023, 2047, 2047};
		reconfigure(setting);
		repeat (20)
			pixel_backlog.push_back(16'($urandom_range(0, 65535)));
		setting = '{1023, -1024, 2047, 2047, 0, 0, 1024, 1024};
		reconfigure(setting);
		repeat (20)
			pixel_backlog.push_back(16'($urandom_range(0, 65535)));

		while (pixels_taken < 1900) begin
			random_setting(setting);
			reconfigure(setting);
			n_pixels = $urandom_range(60, 160);
			repeat (n_pixels) begin
				px = 16'($urandom_range(0, 65535));
				if ($urandom_range(0, 3) != 0)
					px[OpaqueBit] = 1'b1;
				pixel_backlog.push_back(px);
			end
		end

		wait_idle();
		repeat (8) @(posedge clk);
		if (fault_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
